### src/cov_pkg.sv
`timescale 1ns / 1ps

package cov_pkg;

  typedef struct packed {
    logic zero;
    logic one;
  } cov_flag_t;

  localparam int FLAG_BITS = $bits(cov_flag_t);

endpackage

### src/cov_if.sv
`timescale 1ns / 1ps

interface cov_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_start_x;
  logic signed [COORD_BITS-1:0] a_start_y;
  logic signed [COORD_BITS-1:0] a_end_x;
  logic signed [COORD_BITS-1:0] a_end_y;
  logic signed [COORD_BITS-1:0] b_start_x;
  logic signed [COORD_BITS-1:0] b_start_y;
  logic signed [COORD_BITS-1:0] b_end_x;
  logic signed [COORD_BITS-1:0] b_end_y;
  logic        [COORD_BITS-2:0] radius_a;
  logic        [COORD_BITS-2:0] radius_b;
  logic                         b_enabled;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y, radius_a, radius_b, b_enabled,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y, radius_a, radius_b, b_enabled,
    output ready
  );
endinterface

interface cov_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

### src/capsule_overlap_test_2d.sv
`timescale 1ns / 1ps
// Overlap test for two 2D capsules (segment endpoints plus radius each).
// req: one word per pair: both segments' endpoints, both radii and the
//   enable flag of capsule B. Taken when req.valid and req.ready are high.
// rsp: one word per req word, in order: hit is set when B is enabled and
//   the closest distance between the segments is at most the radius sum.
// Throughput: one word per cycle while no stall holds the pipeline, with no
//   bubbles between back-to-back words.
// Path: front, divider for s, t prep, divider for t, distance. The two
//   bit-per-stage dividers produce the segment parameters s and t, one
//   stage per quotient bit.
// Stall: the whole pipeline advances on one enable; while rsp.valid is high
//   and rsp.ready is low, every stage holds and req.ready is low.
// Reset: rst is synchronous; it empties the pipeline and drops rsp.valid.
//   Data registers are not cleared.

module capsule_overlap_test_2d #(
  parameter int COORD_BITS      = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  cov_in_if.sink    req,
  cov_out_if.source rsp
);
  import cov_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int P   = PARAM_FRAC_BITS;
  localparam int VW  = CB + 1;
  localparam int PW  = 2 * CB + 3;
  localparam int SW1 = FLAG_BITS + 3 * PW + 6 * VW + CB + 1;
  localparam int SW2 = FLAG_BITS + P + 1 + 6 * VW + CB + 1;

  logic           ce;
  logic           f_valid, d1_valid, tp_valid, d2_valid, hit_valid, hit;
  logic [PW-1:0]  f_rem, f_den, tp_rem, tp_den;
  logic [SW1-1:0] f_side, d1_side;
  logic [SW2-1:0] tp_side, d2_side;
  logic [P-1:0]   d1_quot, tp_low, d2_quot;

  assign ce = !rsp.valid || rsp.ready;

  cov_front #(.COORD_BITS(CB), .PARAM_FRAC_BITS(P), .PW(PW), .SW(SW1)) u_front (
    .clk, .rst, .ce, .req,
    .out_valid(f_valid), .out_rem(f_rem), .out_den(f_den), .out_side(f_side)
  );

  cov_div #(.NW(PW), .QW(P), .SW(SW1)) u_div_s (
    .clk, .rst, .ce,
    .in_valid(f_valid), .in_rem(f_rem), .in_low('0), .in_den(f_den), .in_side(f_side),
    .out_valid(d1_valid), .out_quot(d1_quot), .out_side(d1_side)
  );

  cov_tprep #(
    .COORD_BITS(CB), .PARAM_FRAC_BITS(P), .PW(PW), .SW_IN(SW1), .SW_OUT(SW2)
  ) u_tprep (
    .clk, .rst, .ce,
    .in_valid(d1_valid), .in_quot(d1_quot), .in_side(d1_side),
    .out_valid(tp_valid), .out_rem(tp_rem), .out_low(tp_low), .out_den(tp_den),
    .out_side(tp_side)
  );

  cov_div #(.NW(PW), .QW(P), .SW(SW2)) u_div_t (
    .clk, .rst, .ce,
    .in_valid(tp_valid), .in_rem(tp_rem), .in_low(tp_low), .in_den(tp_den),
    .in_side(tp_side),
    .out_valid(d2_valid), .out_quot(d2_quot), .out_side(d2_side)
  );

  cov_dist #(.COORD_BITS(CB), .PARAM_FRAC_BITS(P), .SW(SW2)) u_dist (
    .clk, .rst, .ce,
    .in_valid(d2_valid), .in_quot(d2_quot), .in_side(d2_side),
    .out_valid(hit_valid), .out_hit(hit)
  );

  assign rsp.valid = hit_valid;
  assign rsp.hit   = hit;

endmodule

### src/cov_div.sv
`timescale 1ns / 1ps

module cov_div #(
  parameter int NW = 35,
  parameter int QW = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_valid,
  input  logic [NW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [NW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic          valid_q [QW+1];
  logic [NW-1:0] rem_q   [QW+1];
  logic [QW-1:0] low_q   [QW+1];
  logic [QW-1:0] quot_q  [QW+1];
  logic [NW-1:0] den_q   [QW+1];
  logic [SW-1:0] side_q  [QW+1];

  assign valid_q[0] = in_valid;
  assign rem_q[0]   = in_rem;
  assign low_q[0]   = in_low;
  assign quot_q[0]  = '0;
  assign den_q[0]   = in_den;
  assign side_q[0]  = in_side;

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    logic [NW:0] trial;
    logic        ge;

    assign trial = {rem_q[i-1], low_q[i-1][QW-1]};
    assign ge    = trial >= {1'b0, den_q[i-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i] <= 1'b0;
      end else if (ce) begin
        valid_q[i] <= valid_q[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[i]  <= ge ? NW'(trial - {1'b0, den_q[i-1]}) : NW'(trial);
        low_q[i]  <= low_q[i-1] << 1;
        quot_q[i] <= (quot_q[i-1] << 1) | QW'(ge);
        den_q[i]  <= den_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign out_valid = valid_q[QW];
  assign out_quot  = quot_q[QW];
  assign out_side  = side_q[QW];

endmodule

### src/cov_front.sv
`timescale 1ns / 1ps

module cov_front #(
  parameter int COORD_BITS      = 16,
  parameter int PARAM_FRAC_BITS = 16,
  parameter int PW              = 2 * COORD_BITS + 3,
  parameter int SW              = 2 + 3 * PW + 6 * (COORD_BITS + 1) + COORD_BITS + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  cov_in_if.sink        req,
  output logic          out_valid,
  output logic [PW-1:0] out_rem,
  output logic [PW-1:0] out_den,
  output logic [SW-1:0] out_side
);
  import cov_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int VW = CB + 1;
  localparam int MW = 2 * VW;

  logic                 v1, v2, v3, v4;
  logic signed [VW-1:0] ux1, uy1, vx1, vy1, wx1, wy1;
  logic signed [VW-1:0] ux2, uy2, vx2, vy2, wx2, wy2;
  logic signed [VW-1:0] ux3, uy3, vx3, vy3, wx3, wy3;
  logic signed [VW-1:0] ux4, uy4, vx4, vy4, wx4, wy4;
  logic [CB-1:0]        rs1, rs2, rs3, rs4;
  logic                 en1, en2, en3, en4;
  logic signed [MW-1:0] p_uxvy, p_uyvx, p_vxwy, p_vywx, p_uxvx, p_uyvy;
  logic signed [MW-1:0] p_vxvx, p_vyvy, p_vxwx, p_vywy;
  logic signed [PW-1:0] den3, num3, b3, c3, e3;
  logic signed [PW-1:0] b4, c4, e4;
  logic [PW-1:0]        nmag, dmag, n4, d4;
  cov_flag_t            flag4;

  assign req.ready = ce;
  assign nmag = num3[PW-1] ? PW'(-num3) : PW'(num3);
  assign dmag = den3[PW-1] ? PW'(-den3) : PW'(den3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (ce) begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ux1 <= VW'(req.a_end_x) - VW'(req.a_start_x);
      uy1 <= VW'(req.a_end_y) - VW'(req.a_start_y);
      vx1 <= VW'(req.b_end_x) - VW'(req.b_start_x);
      vy1 <= VW'(req.b_end_y) - VW'(req.b_start_y);
      wx1 <= VW'(req.a_start_x) - VW'(req.b_start_x);
      wy1 <= VW'(req.a_start_y) - VW'(req.b_start_y);
      rs1 <= CB'(req.radius_a) + CB'(req.radius_b);
      en1 <= req.b_enabled;

      p_uxvy <= ux1 * vy1;
      p_uyvx <= uy1 * vx1;
      p_vxwy <= vx1 * wy1;
      p_vywx <= vy1 * wx1;
      p_uxvx <= ux1 * vx1;
      p_uyvy <= uy1 * vy1;
      p_vxvx <= vx1 * vx1;
      p_vyvy <= vy1 * vy1;
      p_vxwx <= vx1 * wx1;
      p_vywy <= vy1 * wy1;
      {ux2, uy2, vx2, vy2, wx2, wy2} <= {ux1, uy1, vx1, vy1, wx1, wy1};
      rs2 <= rs1;
      en2 <= en1;

      den3 <= PW'(p_uxvy) - PW'(p_uyvx);
      num3 <= PW'(p_vxwy) - PW'(p_vywx);
      b3   <= PW'(p_uxvx) + PW'(p_uyvy);
      c3   <= PW'(p_vxvx) + PW'(p_vyvy);
      e3   <= PW'(p_vxwx) + PW'(p_vywy);
      {ux3, uy3, vx3, vy3, wx3, wy3} <= {ux2, uy2, vx2, vy2, wx2, wy2};
      rs3 <= rs2;
      en3 <= en2;

      flag4.zero <= (den3 == '0) || (num3 == '0) || (num3[PW-1] != den3[PW-1]);
      flag4.one  <= (den3 != '0) && (num3 != '0) && (num3[PW-1] == den3[PW-1])
                    && (nmag >= dmag);
      n4 <= nmag;
      d4 <= dmag;
      {b4, c4, e4} <= {b3, c3, e3};
      {ux4, uy4, vx4, vy4, wx4, wy4} <= {ux3, uy3, vx3, vy3, wx3, wy3};
      rs4 <= rs3;
      en4 <= en3;
    end
  end

  assign out_valid = v4;
  assign out_rem   = (flag4.zero || flag4.one) ? '0 : n4;
  assign out_den   = d4;
  assign out_side  = {flag4, b4, c4, e4, ux4, uy4, vx4, vy4, wx4, wy4, rs4, en4};

endmodule

### src/cov_tprep.sv
`timescale 1ns / 1ps

module cov_tprep #(
  parameter int COORD_BITS      = 16,
  parameter int PARAM_FRAC_BITS = 16,
  parameter int PW              = 2 * COORD_BITS + 3,
  parameter int SW_IN           = 2 + 3 * PW + 6 * (COORD_BITS + 1) + COORD_BITS + 1,
  parameter int SW_OUT          = 2 + PARAM_FRAC_BITS + 1 + 6 * (COORD_BITS + 1)
                                  + COORD_BITS + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ce,
  input  logic                       in_valid,
  input  logic [PARAM_FRAC_BITS-1:0] in_quot,
  input  logic [SW_IN-1:0]           in_side,
  output logic                       out_valid,
  output logic [PW-1:0]              out_rem,
  output logic [PARAM_FRAC_BITS-1:0] out_low,
  output logic [PW-1:0]              out_den,
  output logic [SW_OUT-1:0]          out_side
);
  import cov_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int P   = PARAM_FRAC_BITS;
  localparam int VW  = CB + 1;
  localparam int NTW = PW + P + 2;

  cov_flag_t            sflag;
  logic signed [PW-1:0] bi, ci, ei;
  logic signed [VW-1:0] uxi, uyi, vxi, vyi, wxi, wyi;
  logic [CB-1:0]        rsi;
  logic                 eni;

  logic                  v1, v2, v3, v4;
  logic [P:0]            s1, s2, s3, s4;
  logic signed [PW-1:0]  b1, c1, e1, c2, e2, c3, c4;
  logic signed [NTW-1:0] bs2, nt3, nt4, cp3;
  logic [VW*6-1:0]       uvw1, uvw2, uvw3, uvw4;
  logic [CB-1:0]         rs1, rs2, rs3, rs4;
  logic                  en1, en2, en3, en4;
  cov_flag_t             tflag4;

  assign {sflag, bi, ci, ei, uxi, uyi, vxi, vyi, wxi, wyi, rsi, eni} = in_side;
  assign cp3 = NTW'(c3) <<< P;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1 <= sflag.one ? (P+1)'(1) << P : (sflag.zero ? '0 : {1'b0, in_quot});
      {b1, c1, e1} <= {bi, ci, ei};
      uvw1 <= {uxi, uyi, vxi, vyi, wxi, wyi};
      rs1  <= rsi;
      en1  <= eni;

      bs2  <= b1 * $signed({1'b0, s1});
      {c2, e2} <= {c1, e1};
      s2   <= s1;
      uvw2 <= uvw1;
      rs2  <= rs1;
      en2  <= en1;

      nt3  <= bs2 + (NTW'(e2) <<< P);
      c3   <= c2;
      s3   <= s2;
      uvw3 <= uvw2;
      rs3  <= rs2;
      en3  <= en2;

      tflag4.zero <= (c3 == '0) || nt3[NTW-1] || (nt3 == '0);
      tflag4.one  <= (c3 != '0) && !nt3[NTW-1] && (nt3 != '0) && (nt3 >= cp3);
      nt4  <= nt3;
      c4   <= c3;
      s4   <= s3;
      uvw4 <= uvw3;
      rs4  <= rs3;
      en4  <= en3;
    end
  end

  assign out_valid = v4;
  assign out_rem   = (tflag4.zero || tflag4.one) ? '0 : nt4[P+PW-1:P];
  assign out_low   = (tflag4.zero || tflag4.one) ? '0 : nt4[P-1:0];
  assign out_den   = c4;
  assign out_side  = {tflag4, s4, uvw4, rs4, en4};

endmodule

### src/cov_dist.sv
`timescale 1ns / 1ps

module cov_dist #(
  parameter int COORD_BITS      = 16,
  parameter int PARAM_FRAC_BITS = 16,
  parameter int SW              = 2 + PARAM_FRAC_BITS + 1 + 6 * (COORD_BITS + 1)
                                  + COORD_BITS + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ce,
  input  logic                       in_valid,
  input  logic [PARAM_FRAC_BITS-1:0] in_quot,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic                       out_hit
);
  import cov_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int P  = PARAM_FRAC_BITS;
  localparam int VW = CB + 1;
  localparam int QW = VW + P + 2;
  localparam int DW = VW + P + 3;
  localparam int RW = CB + P;

  cov_flag_t            tflag;
  logic [P:0]           si;
  logic signed [VW-1:0] uxi, uyi, vxi, vyi, wxi, wyi;
  logic [CB-1:0]        rsi;
  logic                 eni;

  logic                 v1, v2, v3, v4, v5, v6;
  logic [P:0]           s1, t1;
  logic signed [VW-1:0] ux1, uy1, vx1, vy1, wx1, wy1, wx2, wy2;
  logic signed [QW-1:0] pus_x, pus_y, pvt_x, pvt_y;
  logic signed [DW-1:0] dx3, dy3;
  logic [DW-1:0]        mx, my;
  logic [RW-1:0]        r, mx4, my4;
  logic [2*RW-1:0]      sqx5, sqy5;
  logic [2*CB-1:0]      rsq5;
  logic [CB-1:0]        rs1, rs2, rs3, rs4;
  logic                 en1, en2, en3, ok4, ok5, hit6;

  assign {tflag, si, uxi, uyi, vxi, vyi, wxi, wyi, rsi, eni} = in_side;
  assign mx = dx3[DW-1] ? DW'(-dx3) : DW'(dx3);
  assign my = dy3[DW-1] ? DW'(-dy3) : DW'(dy3);
  assign r  = {rs3, {P{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      t1 <= tflag.one ? (P+1)'(1) << P : (tflag.zero ? '0 : {1'b0, in_quot});
      s1 <= si;
      {ux1, uy1, vx1, vy1, wx1, wy1} <= {uxi, uyi, vxi, vyi, wxi, wyi};
      rs1 <= rsi;
      en1 <= eni;

      pus_x <= ux1 * $signed({1'b0, s1});
      pus_y <= uy1 * $signed({1'b0, s1});
      pvt_x <= vx1 * $signed({1'b0, t1});
      pvt_y <= vy1 * $signed({1'b0, t1});
      {wx2, wy2} <= {wx1, wy1};
      rs2 <= rs1;
      en2 <= en1;

      dx3 <= (DW'(wx2) <<< P) + DW'(pus_x) - DW'(pvt_x);
      dy3 <= (DW'(wy2) <<< P) + DW'(pus_y) - DW'(pvt_y);
      rs3 <= rs2;
      en3 <= en2;

      ok4 <= en3 && (mx <= DW'(r)) && (my <= DW'(r));
      mx4 <= mx[RW-1:0];
      my4 <= my[RW-1:0];
      rs4 <= rs3;

      sqx5 <= mx4 * mx4;
      sqy5 <= my4 * my4;
      rsq5 <= rs4 * rs4;
      ok5  <= ok4;

      hit6 <= ok5 && ((2*RW+1)'(sqx5) + (2*RW+1)'(sqy5)
                      <= (2*RW+1)'({rsq5, {(2*P){1'b0}}}));
    end
  end

  assign out_valid = v6;
  assign out_hit   = hit6;

endmodule
